@@ rtl/core/ktrk_pkg.sv @@
package ktrk_pkg;

  localparam int FracBits   = 16;
  localparam int MaxHorizon = 16;
  localparam int DivBits    = 48;

  localparam logic [1:0] OpInit     = 2'd0;
  localparam logic [1:0] OpUpdate   = 2'd1;
  localparam logic [1:0] OpForecast = 2'd2;
  localparam logic [1:0] OpReserved = 2'd3;

  localparam logic [30:0] QReset = 31'd131072;
  localparam logic [30:0] RReset = 31'd327680;

  localparam logic RegProcNoise = 1'b0;
  localparam logic RegMeasNoise = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] measurement;
    logic [4:0]         horizon;
  } ktrk_in_t;

  typedef struct packed {
    logic signed [31:0] level_out;
    logic signed [31:0] slope_out;
    logic               last;
  } ktrk_out_t;

  // controller to datapath
  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_INIT, CMD_PRED, CMD_DIVSTART,
    CMD_DIV0, CMD_DIV1, CMD_MULY, CMD_MULP, CMD_COMMIT, CMD_FC_START, CMD_FC_STEP
  } ktrk_cmd_t;

  typedef struct packed {
    ktrk_cmd_t cmd;
  } ktrk_ctl_t;

  typedef struct packed {
    logic div_done;
    logic s_pos;
  } ktrk_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // floor shift of product then saturate
  function automatic logic signed [31:0] fxmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return sat32(66'(p >>> FracBits));
  endfunction

endpackage

@@ rtl/core/kalman_tracker_2state_unit.sv @@
// two-state constant-velocity kalman tracker, q16.16 fixed point. opcode 0
// loads a level and clears slope and covariance after acceptance with no
// result, and the input is open again the next cycle; opcode 1 runs predict
// and update and shows one word, sooner when the innovation variance is not
// positive and no gain is formed; the shared restoring divider forms both
// gains one quotient bit a cycle; opcode 2 returns horizon forecast words
// (clamped to 16), each later word stepped once the sink takes the one
// before. an update or forecast holds the input until done; an init does not.
module kalman_tracker_2state_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ktrk_pkg::ktrk_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ktrk_pkg::ktrk_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ktrk_pkg::*;

  logic [30:0] q_reg, r_reg;
  ktrk_ctl_t ctl;
  ktrk_sts_t sts;
  ktrk_out_t res;
  ktrk_in_t  in_hold;
  logic      last;

  // config registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      q_reg <= QReset; r_reg <= RReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegProcNoise) q_reg <= pwdata[30:0];
      else r_reg <= pwdata[30:0];
    end
  end
  assign prdata = (paddr[2] == RegProcNoise) ? {1'b0, q_reg} : {1'b0, r_reg};

  // accepted word, held for the datapath while the controller sequences it
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_hold <= in_data;
  end

  ktrk_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_word(in_data),
    .out_valid, .out_stall, .last, .ctl, .sts
  );

  ktrk_datapath u_dp (
    .clk, .rst, .ctl, .sts, .in_word(in_hold), .q_reg, .r_reg, .res
  );

  // filter result shows the new level, forecasts show level + slope*k
  assign out_data.level_out = res.level_out;
  assign out_data.slope_out = res.slope_out;
  assign out_data.last      = last | res.last;
endmodule

@@ rtl/core/ktrk_datapath.sv @@
module ktrk_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ktrk_pkg::ktrk_ctl_t ctl,
  output ktrk_pkg::ktrk_sts_t sts,
  input  ktrk_pkg::ktrk_in_t  in_word,
  input  logic [30:0]         q_reg,
  input  logic [30:0]         r_reg,
  output ktrk_pkg::ktrk_out_t res
);
  import ktrk_pkg::*;

  logic signed [31:0] level, slope, p00, p01, p10, p11;
  logic signed [31:0] z, lk, a00, a01, a10, a11, k0, k1, y;
  logic signed [31:0] m0, m1, m2, m3, m4, m5;
  logic signed [32:0] s;
  // shared restoring divider, one quotient bit a cycle
  logic [DivBits-1:0] dnum, quo;
  logic [DivBits:0]   rem;
  logic [5:0]         dcnt;
  logic               dneg, dbusy;
  logic [DivBits:0]   rem_sh;
  logic [DivBits:0]   dsub;

  assign rem_sh = {rem[DivBits-1:0], dnum[DivBits-1]};
  assign dsub   = rem_sh - {16'd0, s};
  assign sts.div_done = ~dbusy;
  assign sts.s_pos    = (s > 33'sd0);

  function automatic logic signed [31:0] qsat(input logic [DivBits-1:0] q, input logic n);
    logic signed [DivBits:0] v;
    v = n ? -$signed({1'b0, q}) : $signed({1'b0, q});
    return sat32(66'(v));
  endfunction

  // magnitude of a signed word, full range
  function automatic logic [31:0] mag(input logic signed [31:0] v);
    logic signed [32:0] w;
    w = v[31] ? -33'(v) : 33'(v);
    return w[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0; slope <= '0; p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
      dbusy <= 1'b0;
    end else begin
      case (ctl.cmd)
        CMD_LOAD: z <= in_word.measurement;
        CMD_INIT: begin
          level <= in_word.measurement; slope <= '0;
          p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
        end
        CMD_PRED: begin
          lk  <= sat32(66'(level) + 66'(slope));
          a00 <= sat32(66'(p00) + 66'(p01) + 66'(p10) + 66'(p11) + 66'(q_reg));
          a01 <= sat32(66'(p01) + 66'(p11));
          a10 <= sat32(66'(p10) + 66'(p11));
          a11 <= sat32(66'(p11) + 66'(q_reg));
          s   <= 33'(sat32(66'(p00) + 66'(p01) + 66'(p10) + 66'(p11) + 66'(q_reg)))
                 + 33'(r_reg);
          k0 <= '0; k1 <= '0;
        end
        CMD_DIV0, CMD_DIV1: begin
          dneg  <= (ctl.cmd == CMD_DIV0) ? a00[31] : a10[31];
          dnum  <= (ctl.cmd == CMD_DIV0) ? {mag(a00), {FracBits{1'b0}}}
                                         : {mag(a10), {FracBits{1'b0}}};
          rem   <= '0; quo <= '0; dcnt <= 6'(DivBits); dbusy <= 1'b1;
          y     <= sat32(66'(z) - 66'(lk));
        end
        CMD_MULY: begin
          m0 <= fxmul(k0, y); m1 <= fxmul(k1, y);
          m2 <= fxmul(k0, a00); m3 <= fxmul(k0, a01);
          m4 <= fxmul(k1, a00); m5 <= fxmul(k1, a01);
        end
        CMD_COMMIT: begin
          level <= sat32(66'(lk) + 66'(m0));
          slope <= sat32(66'(slope) + 66'(m1));
          p00 <= sat32(66'(a00) - 66'(m2)); p01 <= sat32(66'(a01) - 66'(m3));
          p10 <= sat32(66'(a10) - 66'(m4)); p11 <= sat32(66'(a11) - 66'(m5));
        end
        default: ;
      endcase
      if (dbusy) begin
        dnum <= dnum << 1;
        if (!dsub[DivBits]) begin rem <= dsub; quo <= {quo[DivBits-2:0], 1'b1}; end
        else begin rem <= rem_sh; quo <= {quo[DivBits-2:0], 1'b0}; end
        dcnt <= dcnt - 6'd1;
        if (dcnt == 6'd1) dbusy <= 1'b0;
      end
      if (ctl.cmd == CMD_DIV1) k0 <= qsat(quo, dneg);
      if (ctl.cmd == CMD_MULP) k1 <= qsat(quo, dneg);
    end
  end

  // forecast saturates once, so level + slope*k is formed directly
  // step 0 after an update shows the filtered level itself
  logic [5:0] kk;
  logic signed [31:0] fdirect;
  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_COMMIT) kk <= 6'd0;
    else if (ctl.cmd == CMD_FC_START) kk <= 6'd1;
    else if (ctl.cmd == CMD_FC_STEP) kk <= kk + 6'd1;
  end
  assign fdirect = sat32(66'(level) + 66'(slope) * $signed({1'b0, kk}));

  assign res.level_out = fdirect;
  assign res.slope_out = slope;
  assign res.last      = 1'b0;
endmodule

@@ rtl/core/ktrk_ctrl.sv @@
module ktrk_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ktrk_pkg::ktrk_in_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                last,
  output ktrk_pkg::ktrk_ctl_t ctl,
  input  ktrk_pkg::ktrk_sts_t sts
);
  import ktrk_pkg::*;

  typedef enum logic [3:0] {
    IDLE, PRED, D0, W0, D1, W1, MULY, COMMIT, OUT, FC
  } state_t;

  state_t     state;
  logic [4:0] left;
  ktrk_cmd_t  cmd_next;

  assign in_stall = (state != IDLE);

  // command issued to the datapath at the next edge
  always_comb begin
    cmd_next = CMD_NONE;
    case (state)
      IDLE: if (in_valid) begin
        case (in_word.opcode)
          OpInit:     cmd_next = CMD_INIT;
          OpUpdate:   cmd_next = CMD_LOAD;
          OpForecast: if (in_word.horizon != 5'd0) cmd_next = CMD_FC_START;
          default: ;
        endcase
      end
      PRED:   cmd_next = CMD_PRED;
      D0:     cmd_next = CMD_DIV0;
      W0:     if (sts.div_done && ctl.cmd == CMD_NONE && sts.s_pos) cmd_next = CMD_DIV1;
      W1:     if (sts.div_done && ctl.cmd == CMD_NONE) cmd_next = CMD_MULP;
      MULY:   if (ctl.cmd == CMD_NONE) cmd_next = CMD_MULY;
      COMMIT: if (ctl.cmd == CMD_NONE) cmd_next = CMD_COMMIT;
      FC:     if (out_valid && !out_stall && left != 5'd1) cmd_next = CMD_FC_STEP;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE; out_valid <= 1'b0; ctl.cmd <= CMD_NONE;
      last <= 1'b0; left <= '0;
    end else begin
      ctl.cmd <= cmd_next;
      case (state)
        IDLE: if (in_valid) begin
          case (in_word.opcode)
            OpUpdate: state <= PRED;
            OpForecast: if (in_word.horizon != 5'd0) begin
              left <= (in_word.horizon > 5'(MaxHorizon)) ? 5'(MaxHorizon)
                                                          : in_word.horizon;
              state <= FC;
            end
            default: ;
          endcase
        end
        PRED:   state <= D0;
        D0:     state <= W0;
        W0:     if (sts.div_done && ctl.cmd == CMD_NONE) begin
          if (sts.s_pos) state <= W1;
          else state <= MULY;
        end
        W1:     if (sts.div_done && ctl.cmd == CMD_NONE) state <= MULY;
        MULY:   if (ctl.cmd == CMD_NONE) state <= COMMIT;
        COMMIT: if (ctl.cmd == CMD_NONE) state <= OUT;
        OUT: begin
          if (!out_valid && ctl.cmd == CMD_NONE) begin
            out_valid <= 1'b1; last <= 1'b1;
          end else if (out_valid && !out_stall) begin
            out_valid <= 1'b0; state <= IDLE;
          end
        end
        FC: begin
          if (!out_valid && ctl.cmd == CMD_NONE) begin
            out_valid <= 1'b1; last <= (left == 5'd1);
          end else if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
            left <= left - 5'd1;
            if (left == 5'd1) state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/ktrk_checker.sv @@
module ktrk_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input ktrk_pkg::ktrk_out_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("held word changed");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while word pending");
  a_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid) else $error("word right after input accept");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("valid after reset");
endmodule

bind kalman_tracker_2state_unit ktrk_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
